// ===== hw/rtl/dfc_pkg.sv =====
package dfc_pkg;

	// Default sizing of the task store and of the task fields.
	localparam int MAX_TASKS_DEF     = 64;
	localparam int TIME_BITS_DEF     = 16;
	localparam int DEADLINE_BITS_DEF = 24;

	// Width of the reported task count.
	localparam int CHECKED_BITS = 7;

	// Verdict codes on the result port.
	typedef enum logic [1:0] {
		VERDICT_FEASIBLE   = 2'd0,
		VERDICT_INFEASIBLE = 2'd1,
		VERDICT_OVERFLOW   = 2'd2
	} verdict_t;

endpackage

// ===== hw/rtl/deadline_feasibility_check.sv =====
// Channel  | Signals                                  | Handshake
// ---------+------------------------------------------+---------------------------------
// task in  | task_time, task_deadline, last_task      | beat taken when start & !busy
// result   | verdict, tasks_checked                   | one-cycle beat marked by done
//
// A task goes straight to the place state into an empty store; else each stored task
// with a later deadline is moved up a slot by read/modify/write before it is placed.
// After the last task the walk reads one stored task per cycle, up to the set size,
// and the result beat follows on the next cycle. A task arriving at a full store
// is dropped. Reset clears the count and the overflow flag; the task
// memory itself needs no clearing. The receiver cannot stall the result beat.
module deadline_feasibility_check #(
	parameter int MAX_TASKS     = dfc_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS     = dfc_pkg::TIME_BITS_DEF,
	parameter int DEADLINE_BITS = dfc_pkg::DEADLINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [TIME_BITS-1:0]              task_time,
	input  logic [DEADLINE_BITS-1:0]          task_deadline,
	input  logic                              last_task,
	output logic                              done,
	output logic [1:0]                        verdict,
	output logic [dfc_pkg::CHECKED_BITS-1:0]  tasks_checked
);

	localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW   = $clog2(MAX_TASKS + 1);
	localparam int DW   = TIME_BITS + DEADLINE_BITS;
	localparam int SW   = TIME_BITS + AW;
	localparam int CMPW = (SW > DEADLINE_BITS) ? SW : DEADLINE_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_PLACE = 4'b0100,
		ST_WALK  = 4'b1000
	} state_t;

	state_t                     state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic                       ovf_q, ovf_d;
	logic                       done_q, done_d;
	logic                       fwd_q, fwd_d;
	dfc_pkg::verdict_t          verdict_q, verdict_d;
	logic [CW-1:0]              checked_q, checked_d;
	logic [TIME_BITS-1:0]       time_q, time_d;
	logic [DEADLINE_BITS-1:0]   dl_q, dl_d;
	logic                       last_q, last_d;
	logic [AW-1:0]              pos_q, pos_d;
	logic [AW-1:0]              k_q, k_d;
	logic [SW-1:0]              total_q, total_d;

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [DW-1:0]              mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [DW-1:0]              mem_rdata;
	logic [DW-1:0]              rd_entry;
	logic [TIME_BITS-1:0]       rd_time;
	logic [DEADLINE_BITS-1:0]   rd_dl;
	logic [SW-1:0]              sum;
	logic                       late;
	logic                       accept;
	logic [CW+dfc_pkg::CHECKED_BITS-1:0] checked_ext;

	dfc_ram #(
		.DEPTH (MAX_TASKS),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Stored entry is {time, deadline}. When the last task was just placed in slot 0,
	// the first walk read returns the old contents, so the held task is forwarded.
	assign rd_entry = fwd_q ? {time_q, dl_q} : mem_rdata;
	assign rd_time  = rd_entry[DW-1 -: TIME_BITS];
	assign rd_dl    = rd_entry[DEADLINE_BITS-1:0];

	// Running total of the walk and the lateness test of the current task.
	assign sum  = total_q + SW'(rd_time);
	assign late = CMPW'(sum) > CMPW'(rd_dl);

	assign accept = start && (state_q == ST_IDLE);

	// Insertion shifts later deadlines up one slot per cycle, then the walk checks prefix sums.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ovf_d     = ovf_q;
		done_d    = 1'b0;
		fwd_d     = 1'b0;
		verdict_d = verdict_q;
		checked_d = checked_q;
		time_d    = time_q;
		dl_d      = dl_q;
		last_d    = last_q;
		pos_d     = pos_q;
		k_d       = k_q;
		total_d   = total_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					time_d = task_time;
					dl_d   = task_deadline;
					last_d = last_task;
					if (count_q < MAX_CNT) begin
						if (count_q == '0) begin
							pos_d   = '0;
							state_d = ST_PLACE;
						end else begin
							mem_raddr = AW'(count_q - 1'b1);
							pos_d     = AW'(count_q);
							state_d   = ST_SHIFT;
						end
					end else if (last_task) begin
						// Full store on the last task: report overflow and start over.
						done_d    = 1'b1;
						verdict_d = dfc_pkg::VERDICT_OVERFLOW;
						checked_d = count_q;
						count_d   = '0;
						ovf_d     = 1'b0;
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				if (rd_dl > dl_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = mem_rdata;
					pos_d     = pos_q - 1'b1;
					if (pos_q > AW'(1)) begin
						mem_raddr = pos_q - AW'(2);
					end else begin
						state_d = ST_PLACE;
					end
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = {time_q, dl_q};
				count_d   = count_q + 1'b1;
				if (last_q) begin
					mem_raddr = '0;
					fwd_d     = (pos_q == '0);
					k_d       = '0;
					total_d   = '0;
					state_d   = ST_WALK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				mem_raddr = k_q + 1'b1;
				if (late || (CW'(k_q) == count_q - 1'b1)) begin
					done_d    = 1'b1;
					verdict_d = late ? dfc_pkg::VERDICT_INFEASIBLE : dfc_pkg::VERDICT_FEASIBLE;
					checked_d = count_q;
					count_d   = '0;
					ovf_d     = 1'b0;
					state_d   = ST_IDLE;
				end else begin
					k_d     = k_q + 1'b1;
					total_d = sum;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			done_q  <= done_d;
			fwd_q   <= fwd_d;
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		verdict_q <= verdict_d;
		checked_q <= checked_d;
		time_q    <= time_d;
		dl_q      <= dl_d;
		last_q    <= last_d;
		pos_q     <= pos_d;
		k_q       <= k_d;
		total_q   <= total_d;
	end

	// Result ports; the count is reported modulo the port width.
	assign checked_ext   = {{dfc_pkg::CHECKED_BITS{1'b0}}, checked_q};
	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign verdict       = verdict_q;
	assign tasks_checked = checked_ext[dfc_pkg::CHECKED_BITS-1:0];

endmodule

// ===== hw/rtl/dfc_ram.sv =====
module dfc_ram #(
	parameter int DEPTH = dfc_pkg::MAX_TASKS_DEF,
	parameter int AW    = 6,
	parameter int DW    = dfc_pkg::TIME_BITS_DEF + dfc_pkg::DEADLINE_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	// One write port and one read port; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sim/deadline_feasibility_check_tb.sv =====
`timescale 1ns / 100ps

module deadline_feasibility_check_tb;

	localparam int MAX_TASKS    = dfc_pkg::MAX_TASKS_DEF;
	localparam int TIME_W       = dfc_pkg::TIME_BITS_DEF;
	localparam int DEADLINE_W   = dfc_pkg::DEADLINE_BITS_DEF;
	localparam int CHK_W        = dfc_pkg::CHECKED_BITS;
	localparam int ITEM_GOAL    = 450;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * MAX_TASKS + 8;
	localparam int IDLE_PCT     = 13;
	localparam int DIRECTED_ROWS = 17;

	// One task beat, with the verdict typed in where it is obvious.
	typedef struct packed {
		logic [TIME_W-1:0]       run_time;
		logic [DEADLINE_W-1:0]   deadline;
		logic                    last;
		logic                    typed;
		dfc_pkg::verdict_t       verdict;
		logic [CHK_W-1:0]        count;
	} task_row_t;

	typedef struct packed {
		dfc_pkg::verdict_t       verdict;
		logic [CHK_W-1:0]        count;
	} verdict_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [TIME_W-1:0]       task_time;
	logic [DEADLINE_W-1:0]   task_deadline;
	logic                    last_task;
	logic                    done;
	logic [1:0]              verdict;
	logic [CHK_W-1:0]        tasks_checked;

	// Typed expectation that travels with the task beat on the bus.
	logic                    note_typed;
	dfc_pkg::verdict_t       note_verdict;
	logic [CHK_W-1:0]        note_count;

	// Shadow of the task store, kept in deadline order.
	logic [TIME_W-1:0]     held_time [MAX_TASKS];
	logic [DEADLINE_W-1:0] held_deadline [MAX_TASKS];
	int                    held_count = 0;
	bit                    store_full = 1'b0;

	verdict_beat_t pending_verdicts [$];

	int items_sent = 0;
	int tasks_taken = 0;
	int verdicts_seen = 0;
	int feasible_seen = 0;
	int infeasible_seen = 0;
	int overflow_seen = 0;
	int errors = 0;
	int stall_cycles = 0;

	task_row_t directed_rows [DIRECTED_ROWS] = '{
		// Single tasks at the field extremes.
		'{16'h0000, 24'h000000, 1'b1, 1'b1, dfc_pkg::VERDICT_FEASIBLE,   7'd1},
		'{16'h0001, 24'h000000, 1'b1, 1'b1, dfc_pkg::VERDICT_INFEASIBLE, 7'd1},
		'{16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, dfc_pkg::VERDICT_FEASIBLE,   7'd1},
		'{16'hFFFF, 24'h00FFFE, 1'b1, 1'b1, dfc_pkg::VERDICT_INFEASIBLE, 7'd1},
		// Deadlines arriving in reverse order.
		'{16'd10, 24'd100, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd20, 24'd30,  1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd5,  24'd5,   1'b1, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		// Equal deadlines where the second task misses.
		'{16'd10, 24'd15, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd10, 24'd15, 1'b1, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		// Out of order set that misses only on the latest deadline.
		'{16'd10, 24'd20, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd5,  24'd8,  1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd6,  24'd12, 1'b1, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		// Alternating bit patterns.
		'{16'h5555, 24'h555555, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'hAAAA, 24'hAAAAAA, 1'b1, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		// Equal deadlines met exactly.
		'{16'd3, 24'd9, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd3, 24'd9, 1'b0, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0},
		'{16'd3, 24'd9, 1'b1, 1'b0, dfc_pkg::VERDICT_FEASIBLE, 7'd0}
	};

	deadline_feasibility_check u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.task_time    (task_time),
		.task_deadline(task_deadline),
		.last_task    (last_task),
		.done         (done),
		.verdict      (verdict),
		.tasks_checked(tasks_checked)
	);

	always #10 clk = ~clk;

	// Insert an accepted task in deadline order and, on the last one, queue the verdict.
	task automatic edf_accept(input logic [TIME_W-1:0] t, input logic [DEADLINE_W-1:0] d,
			input logic l, input logic typed, input dfc_pkg::verdict_t typed_verdict,
			input logic [CHK_W-1:0] typed_count);
		verdict_beat_t beat;
		int            pos;
		logic [31:0]   total;
		bit            met;
		if (held_count < MAX_TASKS) begin
			pos = held_count;
			while (pos > 0 && held_deadline[pos-1] > d) begin
				held_time[pos] = held_time[pos-1];
				held_deadline[pos] = held_deadline[pos-1];
				pos--;
			end
			held_time[pos] = t;
			held_deadline[pos] = d;
			held_count++;
		end else begin
			store_full = 1'b1;
		end
		if (l) begin
			if (store_full) begin
				beat.verdict = dfc_pkg::VERDICT_OVERFLOW;
			end else begin
				// Walk in deadline order and accumulate run time.
				total = '0;
				met = 1'b1;
				for (int k = 0; k < held_count; k++) begin
					total = total + held_time[k];
					if (total > held_deadline[k])
						met = 1'b0;
				end
				beat.verdict = met ? dfc_pkg::VERDICT_FEASIBLE : dfc_pkg::VERDICT_INFEASIBLE;
			end
			beat.count = CHK_W'(held_count);
			if (typed) begin
				beat.verdict = typed_verdict;
				beat.count = typed_count;
			end
			pending_verdicts.push_back(beat);
			held_count = 0;
			store_full = 1'b0;
		end
	endtask

	// Compare a result beat with the oldest pending verdict.
	task automatic check_verdict();
		verdict_beat_t want;
		if (pending_verdicts.size() == 0) begin
			$error("result beat with no verdict pending: verdict %0d, tasks_checked %0d",
				verdict, tasks_checked);
			errors++;
		end else begin
			want = pending_verdicts.pop_front();
			verdicts_seen++;
			case (want.verdict)
				dfc_pkg::VERDICT_FEASIBLE:   feasible_seen++;
				dfc_pkg::VERDICT_INFEASIBLE: infeasible_seen++;
				default:                     overflow_seen++;
			endcase
			if (verdict !== want.verdict) begin
				$error("verdict: expected %0d, actual %0d", want.verdict, verdict);
				errors++;
			end
			if (tasks_checked !== want.count) begin
				$error("tasks_checked: expected %0d, actual %0d", want.count, tasks_checked);
				errors++;
			end
		end
	endtask

	// Monitor both channels at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_verdict();
			if (start && !busy) begin
				tasks_taken++;
				edf_accept(task_time, task_deadline, last_task, note_typed, note_verdict,
					note_count);
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d verdicts still pending",
				stall_cycles, pending_verdicts.size());
			$display("deadline_feasibility_check_tb NOT OK");
			$finish;
		end
	end

	// Random idle cycles on the task channel, except in the quiet stretch.
	task automatic sender_pause();
		bit quiet;
		quiet = (items_sent >= 150 && items_sent < 300);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			task_time <= TIME_W'($urandom);
			task_deadline <= DEADLINE_W'($urandom);
			last_task <= 1'($urandom);
			@(posedge clk);
		end
	endtask

	// Present one task beat and hold it until the block takes it.
	task automatic send_task(input task_row_t row);
		start <= 1'b1;
		task_time <= row.run_time;
		task_deadline <= row.deadline;
		last_task <= row.last;
		note_typed <= row.typed;
		note_verdict <= row.verdict;
		note_count <= row.count;
		items_sent++;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		task_row_t row;
		int        set_idx;
		int        set_size;
		int        set_mode;
		int        pick;
		int        acc;
		int        slack;
		start = 1'b0;
		task_time = '0;
		task_deadline = '0;
		last_task = 1'b0;
		note_typed = 1'b0;
		note_verdict = dfc_pkg::VERDICT_FEASIBLE;
		note_count = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets.
		foreach (directed_rows[i]) begin
			sender_pause();
			send_task(directed_rows[i]);
		end

		// Random sets: mostly small, a few filling or overflowing the store.
		set_idx = 0;
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(0, 99);
			if (set_idx == 4)
				set_size = MAX_TASKS;
			else if (set_idx == 9)
				set_size = MAX_TASKS + 2;
			else if (pick < 2)
				set_size = MAX_TASKS;
			else if (pick < 4)
				set_size = MAX_TASKS + $urandom_range(1, 4);
			else if (pick < 12)
				set_size = $urandom_range(9, 24);
			else
				set_size = $urandom_range(1, 8);
			set_mode = $urandom_range(0, 2);
			acc = 0;
			row = '0;
			for (int n = 0; n < set_size; n++) begin
				if (set_mode == 2 || $urandom_range(0, 3) == 0)
					row.run_time = TIME_W'($urandom);
				else
					row.run_time = TIME_W'($urandom_range(0, 300));
				acc += row.run_time;
				// Reuse the previous deadline now and then to make ties.
				if (n > 0 && $urandom_range(0, 99) < 15) begin
					row.deadline = row.deadline;
				end else if (set_mode == 0) begin
					slack = acc + int'($urandom_range(0, 40)) - 20;
					if (slack < 0)
						slack = 0;
					row.deadline = DEADLINE_W'(slack);
				end else if (set_mode == 1) begin
					row.deadline = DEADLINE_W'(acc + int'($urandom_range(0, 3000)));
				end else begin
					row.deadline = DEADLINE_W'($urandom);
				end
				row.last = (n == set_size - 1);
				row.typed = 1'b0;
				sender_pause();
				send_task(row);
			end
			set_idx++;
		end
		start <= 1'b0;

		// Let the last verdicts arrive, then keep the clock running for stray beats.
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d task beats in %0d sets; %0d verdicts checked.",
			tasks_taken, verdicts_seen, verdicts_seen);
		$display("Verdicts: %0d feasible, %0d infeasible, %0d overflow; %0d mismatches.",
			feasible_seen, infeasible_seen, overflow_seen, errors);
		if (errors == 0)
			$display("deadline_feasibility_check_tb OK");
		else
			$display("deadline_feasibility_check_tb NOT OK");
		$finish;
	end

endmodule
